// ----- src/ebcpu_pkg.sv -----
// Shared types, codes and ALU flag functions of the 8-bit CPU instruction-step core.
`default_nettype none
package ebcpu_pkg;

	// Default size of the byte memory.
	localparam int EBCPU_MEM_DEPTH = 65536;

	// Width of the memory limit register.
	localparam int LIMIT_W = 17;

	// Reset value of the memory limit.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	// Request kinds.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_EXEC  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNIMPL = 2'd1;
	localparam logic [1:0] ST_HALTED = 2'd2;

	// Flag bit masks.
	localparam logic [7:0] FL_H    = 8'h10;
	localparam logic [7:0] FL_N    = 8'h02;
	localparam logic [7:0] FL_C    = 8'h01;
	localparam logic [7:0] FL_KEEP = 8'hC4;

	// Opcodes that are decoded individually.
	localparam logic [7:0] OPC_LD_BC_A  = 8'h02;
	localparam logic [7:0] OPC_LD_DE_A  = 8'h12;
	localparam logic [7:0] OPC_LD_A_BC  = 8'h0A;
	localparam logic [7:0] OPC_LD_A_DE  = 8'h1A;
	localparam logic [7:0] OPC_LD_NN_HL = 8'h22;
	localparam logic [7:0] OPC_LD_HL_NN = 8'h2A;
	localparam logic [7:0] OPC_LD_NN_A  = 8'h32;
	localparam logic [7:0] OPC_LD_A_NN  = 8'h3A;
	localparam logic [7:0] OPC_HALT     = 8'h76;
	localparam logic [7:0] OPC_FIRST_UNIMPL = 8'h90;

	// Operand index that selects the byte at HL.
	localparam logic [2:0] IDX_MEM_HL = 3'd6;
	localparam logic [2:0] IDX_ACC    = 3'd7;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RDW,
		S_OPC,
		S_IMM_LO,
		S_IMM_HI,
		S_WR_HI,
		S_OPND,
		S_OPND2,
		S_CHK,
		S_RESP
	} st_t;

	// Increment: result byte in the upper half, flags in the lower half.
	function automatic logic [15:0] f_inc(input logic [7:0] old, input logic [7:0] f);
		logic [7:0] r;
		r = old + 8'd1;
		return {r, r[7], (r == 8'h00), 1'b0, (old[3:0] == 4'hF), 1'b0,
			(old == 8'h7F), 1'b0, f[0]};
	endfunction

	// Decrement: result byte in the upper half, flags in the lower half.
	function automatic logic [15:0] f_dec(input logic [7:0] old, input logic [7:0] f);
		logic [7:0] r;
		r = old - 8'd1;
		return {r, r[7], (r == 8'h00), 1'b0, (old[3:0] == 4'h0), 1'b0,
			(old == 8'h80), 1'b1, f[0]};
	endfunction

	// Eight-bit add with carry in: result byte, then flags.
	function automatic logic [15:0] f_add8(input logic [7:0] a, input logic [7:0] b,
			input logic cin);
		logic [8:0] s;
		logic [4:0] hs;
		logic [7:0] r;
		logic v;
		s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
		hs = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
		r = s[7:0];
		v = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
		return {r, r[7], (r == 8'h00), 1'b0, hs[4], 1'b0, v, 1'b0, s[8]};
	endfunction

endpackage
`default_nettype wire

// ----- src/ebcpu_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
`default_nettype none
module ebcpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle; a read returns data on the next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/eight_bit_cpu_instruction_step.sv -----
// Top level of the 8-bit CPU instruction-step core: sequencer, registers and byte memory.
`default_nettype none
// Each input transaction writes a memory byte, reads a memory byte or executes the one
// instruction at the program counter (opcodes 0x00-0x8F except DAA), and yields exactly one
// result transaction with the status and the processor state after the step. All memory
// traffic goes through one single-port RAM with a registered read, so each memory access
// has a sequencer state of its own. A write or a read makes its access and then loads the
// result register; an instruction runs through the fetch, up to four immediate or operand
// accesses, a step for the T-state count and the limit check, and a step to load the result.
// A new transaction is accepted once the previous one has reached the result register.
// MEM_DEPTH must be a power of two; addresses select the entry address modulo MEM_DEPTH.
// The memory has no reset; a byte must be written before it is read.
module eight_bit_cpu_instruction_step
	import ebcpu_pkg::*;
#(
	parameter int MEM_DEPTH = EBCPU_MEM_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	// Fields from bit 0: address[15:0], write_data[23:16].
	input  wire logic [23:0]        s_axis_tdata,
	// Fields from bit 0: op[1:0].
	input  wire logic [1:0]         s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// Fields from bit 0: read_data[7:0], prog_counter_out[23:8], accumulator_out[31:24],
	// flags_out[39:32], halted[40], cycle_total[72:41], zero fill[79:73].
	output logic [79:0]             m_axis_tdata,
	// Fields from bit 0: status[1:0].
	output logic [1:0]              m_axis_tuser,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [LIMIT_W-1:0] cfg_data
);

	localparam int AW = $clog2(MEM_DEPTH);

	st_t state_q, state_d;

	// Architectural registers.
	logic [7:0]  acc_q, flg_q, alt_acc_q, alt_flg_q;
	logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q;
	logic [15:0] sp_q, pc_q, pc_d;
	logic [31:0] cyc_q;
	logic        halt_q;
	logic [LIMIT_W-1:0] limit_q;

	// Per-transaction working registers.
	logic [7:0]  opc_q, lo_q;
	logic [15:0] addr_q;
	logic [4:0]  tst_q;
	logic [1:0]  stat_q;
	logic [7:0]  rd_q;

	// Result register.
	logic        out_valid_q;
	logic [1:0]  out_stat_q;
	logic [72:0] out_data_q;

	// Memory port.
	logic        mem_en, mem_we;
	logic [15:0] mem_addr;
	logic [7:0]  mem_wdata, mem_rdata;

	// Register write requests from the sequencer.
	logic        r8_we, pr_we, fl_we, ex_en, halt_set;
	logic [2:0]  r8_idx;
	logic [7:0]  r8_val, fl_val;
	logic [1:0]  pr_idx;
	logic [15:0] pr_val;
	logic        opc_ld, lo_ld, addr_ld, tst_ld, stat_ld, rd_ld, chk_en, out_ld;
	logic [7:0]  lo_d, rd_d;
	logic [15:0] addr_d;
	logic [4:0]  tst_d;
	logic [1:0]  stat_d;

	logic        in_fire;
	logic [1:0]  in_op;
	logic [15:0] in_addr;
	logic [7:0]  in_wdata;

	assign in_op    = s_axis_tuser;
	assign in_addr  = s_axis_tdata[15:0];
	assign in_wdata = s_axis_tdata[23:16];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Eight-bit operand select; the byte at HL is handled by the sequencer.
	function automatic logic [7:0] sel8(input logic [2:0] i, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
			input logic [7:0] h, input logic [7:0] l, input logic [7:0] a);
		logic [7:0] v;
		case (i)
			3'd0: v = b;
			3'd1: v = c;
			3'd2: v = d;
			3'd3: v = e;
			3'd4: v = h;
			3'd5: v = l;
			IDX_ACC: v = a;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Byte memory.
	ebcpu_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr[AW-1:0]),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// Sequencer: decode, memory requests and register write requests.
	always_comb begin
		logic [7:0]  opc, rv;
		logic [2:0]  rr, ss;
		logic [1:0]  pp;
		logic [15:0] hl, pv, bc, de, res, nn;
		logic [16:0] s17;
		logic [12:0] s13;
		logic        take;

		state_d = state_q;
		pc_d = pc_q;
		mem_en = 1'b0;
		mem_we = 1'b0;
		mem_addr = pc_q;
		mem_wdata = 8'h00;
		r8_we = 1'b0;
		r8_idx = IDX_ACC;
		r8_val = 8'h00;
		pr_we = 1'b0;
		pr_idx = 2'd0;
		pr_val = 16'h0000;
		fl_we = 1'b0;
		fl_val = flg_q;
		ex_en = 1'b0;
		halt_set = 1'b0;
		opc_ld = 1'b0;
		lo_ld = 1'b0;
		lo_d = mem_rdata;
		addr_ld = 1'b0;
		addr_d = 16'h0000;
		tst_ld = 1'b0;
		tst_d = 5'd0;
		stat_ld = 1'b0;
		stat_d = ST_OK;
		rd_ld = 1'b0;
		rd_d = 8'h00;
		chk_en = 1'b0;
		out_ld = 1'b0;

		opc = (state_q == S_OPC) ? mem_rdata : opc_q;
		rr = opc[5:3];
		ss = opc[2:0];
		pp = opc[5:4];
		hl = {h_q, l_q};
		bc = {b_q, c_q};
		de = {d_q, e_q};
		nn = {mem_rdata, lo_q};
		rv = sel8(ss, b_q, c_q, d_q, e_q, h_q, l_q, acc_q);
		case (pp)
			2'd0: pv = bc;
			2'd1: pv = de;
			2'd2: pv = hl;
			default: pv = sp_q;
		endcase
		res = 16'h0000;
		s17 = 17'd0;
		s13 = 13'd0;
		take = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					stat_ld = 1'b1;
					rd_ld = 1'b1;
					case (in_op)
						OP_WRITE: begin
							mem_en = 1'b1;
							mem_we = 1'b1;
							mem_addr = in_addr;
							mem_wdata = in_wdata;
							state_d = S_RESP;
						end
						OP_READ: begin
							mem_en = 1'b1;
							mem_addr = in_addr;
							state_d = S_RDW;
						end
						OP_EXEC: begin
							if (halt_q) begin
								stat_d = ST_HALTED;
								state_d = S_RESP;
							end else begin
								mem_en = 1'b1;
								mem_addr = pc_q;
								pc_d = pc_q + 16'd1;
								state_d = S_OPC;
							end
						end
						default: begin
							stat_d = ST_UNIMPL;
							state_d = S_RESP;
						end
					endcase
				end
			end

			S_RDW: begin
				rd_ld = 1'b1;
				rd_d = mem_rdata;
				state_d = S_RESP;
			end

			S_OPC: begin
				opc_ld = 1'b1;
				tst_ld = 1'b1;
				state_d = S_CHK;
				if (opc >= OPC_FIRST_UNIMPL) begin
					stat_ld = 1'b1;
					stat_d = ST_UNIMPL;
				end else if (opc[7]) begin
					// ADD and ADC
					if (ss == IDX_MEM_HL) begin
						mem_en = 1'b1;
						mem_addr = hl;
						tst_d = 5'd7;
						state_d = S_OPND;
					end else begin
						res = f_add8(acc_q, rv, opc[3] & flg_q[0]);
						r8_we = 1'b1;
						r8_val = res[15:8];
						fl_we = 1'b1;
						fl_val = res[7:0];
						tst_d = 5'd4;
					end
				end else if (opc[6]) begin
					// Eight-bit register moves and HALT
					if (opc == OPC_HALT) begin
						halt_set = 1'b1;
						pc_d = pc_q - 16'd1;
						tst_d = 5'd4;
					end else if (ss == IDX_MEM_HL) begin
						mem_en = 1'b1;
						mem_addr = hl;
						tst_d = 5'd7;
						state_d = S_OPND;
					end else if (rr == IDX_MEM_HL) begin
						mem_en = 1'b1;
						mem_we = 1'b1;
						mem_addr = hl;
						mem_wdata = rv;
						tst_d = 5'd7;
					end else begin
						r8_we = 1'b1;
						r8_idx = rr;
						r8_val = rv;
						tst_d = 5'd4;
					end
				end else begin
					case (ss)
						3'd4, 3'd5: begin
							if (rr == IDX_MEM_HL) begin
								mem_en = 1'b1;
								mem_addr = hl;
								tst_d = 5'd11;
								state_d = S_OPND;
							end else begin
								res = ss[0] ?
									f_dec(sel8(rr, b_q, c_q, d_q, e_q, h_q, l_q, acc_q), flg_q) :
									f_inc(sel8(rr, b_q, c_q, d_q, e_q, h_q, l_q, acc_q), flg_q);
								r8_we = 1'b1;
								r8_idx = rr;
								r8_val = res[15:8];
								fl_we = 1'b1;
								fl_val = res[7:0];
								tst_d = 5'd4;
							end
						end
						3'd6: begin
							mem_en = 1'b1;
							pc_d = pc_q + 16'd1;
							tst_d = (rr == IDX_MEM_HL) ? 5'd10 : 5'd7;
							state_d = S_IMM_LO;
						end
						3'd1: begin
							if (opc[3]) begin
								// ADD HL,pair
								s17 = {1'b0, hl} + {1'b0, pv};
								s13 = {1'b0, hl[11:0]} + {1'b0, pv[11:0]};
								pr_we = 1'b1;
								pr_idx = 2'd2;
								pr_val = s17[15:0];
								fl_we = 1'b1;
								fl_val = (flg_q & FL_KEEP) | (s13[12] ? FL_H : 8'h00) |
									(s17[16] ? FL_C : 8'h00);
								tst_d = 5'd11;
							end else begin
								mem_en = 1'b1;
								pc_d = pc_q + 16'd1;
								tst_d = 5'd10;
								state_d = S_IMM_LO;
							end
						end
						3'd3: begin
							pr_we = 1'b1;
							pr_idx = pp;
							pr_val = opc[3] ? (pv - 16'd1) : (pv + 16'd1);
							tst_d = 5'd6;
						end
						3'd2: begin
							tst_d = 5'd7;
							case (opc)
								OPC_LD_BC_A, OPC_LD_DE_A: begin
									mem_en = 1'b1;
									mem_we = 1'b1;
									mem_addr = opc[4] ? de : bc;
									mem_wdata = acc_q;
								end
								OPC_LD_A_BC, OPC_LD_A_DE: begin
									mem_en = 1'b1;
									mem_addr = opc[4] ? de : bc;
									state_d = S_OPND;
								end
								default: begin
									mem_en = 1'b1;
									pc_d = pc_q + 16'd1;
									tst_d = opc[4] ? 5'd13 : 5'd16;
									state_d = S_IMM_LO;
								end
							endcase
						end
						3'd7: begin
							tst_d = 5'd4;
							fl_we = 1'b1;
							r8_val = acc_q;
							case (rr)
								3'd0: begin
									r8_we = 1'b1;
									r8_val = {acc_q[6:0], acc_q[7]};
									fl_val = (flg_q & FL_KEEP) | {7'd0, acc_q[7]};
								end
								3'd1: begin
									r8_we = 1'b1;
									r8_val = {acc_q[0], acc_q[7:1]};
									fl_val = (flg_q & FL_KEEP) | {7'd0, acc_q[0]};
								end
								3'd2: begin
									r8_we = 1'b1;
									r8_val = {acc_q[6:0], flg_q[0]};
									fl_val = (flg_q & FL_KEEP) | {7'd0, acc_q[7]};
								end
								3'd3: begin
									r8_we = 1'b1;
									r8_val = {flg_q[0], acc_q[7:1]};
									fl_val = (flg_q & FL_KEEP) | {7'd0, acc_q[0]};
								end
								3'd4: begin
									// DAA is not implemented.
									fl_we = 1'b0;
									tst_d = 5'd0;
									stat_ld = 1'b1;
									stat_d = ST_UNIMPL;
								end
								3'd5: begin
									r8_we = 1'b1;
									r8_val = ~acc_q;
									fl_val = flg_q | FL_H | FL_N;
								end
								3'd6: begin
									fl_val = (flg_q & FL_KEEP) | FL_C;
								end
								default: begin
									fl_val = (flg_q & FL_KEEP) | (flg_q[0] ? FL_H : FL_C);
								end
							endcase
						end
						default: begin
							// NOP, EX AF, DJNZ and relative jumps
							tst_d = 5'd4;
							case (rr)
								3'd0: take = 1'b0;
								3'd1: ex_en = 1'b1;
								3'd2: begin
									r8_we = 1'b1;
									r8_idx = 3'd0;
									r8_val = b_q - 8'd1;
									take = (b_q != 8'h01);
								end
								3'd3: take = 1'b1;
								3'd4: take = ~flg_q[6];
								3'd5: take = flg_q[6];
								3'd6: take = ~flg_q[0];
								default: take = flg_q[0];
							endcase
							if (rr >= 3'd2) begin
								pc_d = pc_q + 16'd1;
								if (take) begin
									mem_en = 1'b1;
									tst_d = (rr == 3'd2) ? 5'd13 : 5'd12;
									state_d = S_IMM_LO;
								end else begin
									tst_d = (rr == 3'd2) ? 5'd8 : 5'd7;
								end
							end
						end
					endcase
				end
			end

			S_IMM_LO: begin
				lo_ld = 1'b1;
				state_d = S_CHK;
				if (ss == 3'd0) begin
					pc_d = pc_q + {{8{mem_rdata[7]}}, mem_rdata};
				end else if (ss == 3'd6) begin
					if (rr == IDX_MEM_HL) begin
						mem_en = 1'b1;
						mem_we = 1'b1;
						mem_addr = hl;
						mem_wdata = mem_rdata;
					end else begin
						r8_we = 1'b1;
						r8_idx = rr;
						r8_val = mem_rdata;
					end
				end else begin
					mem_en = 1'b1;
					pc_d = pc_q + 16'd1;
					state_d = S_IMM_HI;
				end
			end

			S_IMM_HI: begin
				addr_ld = 1'b1;
				addr_d = nn;
				state_d = S_CHK;
				if (ss == 3'd1) begin
					pr_we = 1'b1;
					pr_idx = pp;
					pr_val = nn;
				end else begin
					case (opc)
						OPC_LD_NN_HL: begin
							mem_en = 1'b1;
							mem_we = 1'b1;
							mem_addr = nn;
							mem_wdata = l_q;
							state_d = S_WR_HI;
						end
						OPC_LD_NN_A: begin
							mem_en = 1'b1;
							mem_we = 1'b1;
							mem_addr = nn;
							mem_wdata = acc_q;
						end
						default: begin
							mem_en = 1'b1;
							mem_addr = nn;
							state_d = S_OPND;
						end
					endcase
				end
			end

			S_WR_HI: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
				mem_addr = addr_q + 16'd1;
				mem_wdata = h_q;
				state_d = S_CHK;
			end

			S_OPND: begin
				state_d = S_CHK;
				if (opc[7]) begin
					res = f_add8(acc_q, mem_rdata, opc[3] & flg_q[0]);
					r8_we = 1'b1;
					r8_val = res[15:8];
					fl_we = 1'b1;
					fl_val = res[7:0];
				end else if (opc[6]) begin
					r8_we = 1'b1;
					r8_idx = rr;
					r8_val = mem_rdata;
				end else if (ss == 3'd4 || ss == 3'd5) begin
					res = ss[0] ? f_dec(mem_rdata, flg_q) : f_inc(mem_rdata, flg_q);
					mem_en = 1'b1;
					mem_we = 1'b1;
					mem_addr = hl;
					mem_wdata = res[15:8];
					fl_we = 1'b1;
					fl_val = res[7:0];
				end else if (opc == OPC_LD_HL_NN) begin
					r8_we = 1'b1;
					r8_idx = 3'd5;
					r8_val = mem_rdata;
					mem_en = 1'b1;
					mem_addr = addr_q + 16'd1;
					state_d = S_OPND2;
				end else begin
					r8_we = 1'b1;
					r8_val = mem_rdata;
				end
			end

			S_OPND2: begin
				r8_we = 1'b1;
				r8_idx = 3'd4;
				r8_val = mem_rdata;
				state_d = S_CHK;
			end

			S_CHK: begin
				chk_en = 1'b1;
				state_d = S_RESP;
			end

			S_RESP: begin
				if (!out_valid_q || m_axis_tready) begin
					out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural registers and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'h00;
			flg_q <= 8'h00;
			alt_acc_q <= 8'h00;
			alt_flg_q <= 8'h00;
			b_q <= 8'h00;
			c_q <= 8'h00;
			d_q <= 8'h00;
			e_q <= 8'h00;
			h_q <= 8'h00;
			l_q <= 8'h00;
			sp_q <= 16'h0000;
			pc_q <= 16'h0000;
			cyc_q <= 32'd0;
			halt_q <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else begin
			pc_q <= pc_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (r8_we) begin
				case (r8_idx)
					3'd0: b_q <= r8_val;
					3'd1: c_q <= r8_val;
					3'd2: d_q <= r8_val;
					3'd3: e_q <= r8_val;
					3'd4: h_q <= r8_val;
					3'd5: l_q <= r8_val;
					IDX_ACC: acc_q <= r8_val;
					default: acc_q <= acc_q;
				endcase
			end
			if (pr_we) begin
				case (pr_idx)
					2'd0: {b_q, c_q} <= pr_val;
					2'd1: {d_q, e_q} <= pr_val;
					2'd2: {h_q, l_q} <= pr_val;
					default: sp_q <= pr_val;
				endcase
			end
			if (fl_we) begin
				flg_q <= fl_val;
			end
			if (ex_en) begin
				acc_q <= alt_acc_q;
				alt_acc_q <= acc_q;
				flg_q <= alt_flg_q;
				alt_flg_q <= flg_q;
			end
			if (halt_set || (chk_en && ({1'b0, pc_q} >= limit_q))) begin
				halt_q <= 1'b1;
			end
			if (chk_en) begin
				cyc_q <= cyc_q + {27'd0, tst_q};
			end
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (opc_ld) begin
			opc_q <= mem_rdata;
		end
		if (lo_ld) begin
			lo_q <= lo_d;
		end
		if (addr_ld) begin
			addr_q <= addr_d;
		end
		if (tst_ld) begin
			tst_q <= tst_d;
		end
		if (stat_ld) begin
			stat_q <= stat_d;
		end
		if (rd_ld) begin
			rd_q <= rd_d;
		end
		if (out_ld) begin
			out_stat_q <= stat_q;
			out_data_q <= {cyc_q, halt_q, flg_q, acc_q, pc_q, rd_q};
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_stat_q;
	assign m_axis_tdata  = {7'd0, out_data_q};

	// Only reset clears the halt state.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt state cleared without reset");

	// A request refused because of the halt always reports the halt.
	a_halted_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_HALTED)) |-> m_axis_tdata[40])
		else $error("halted status without halt flag");

	// The T-state count moves only in the count and limit check step.
	a_cycle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CHK) |=> $stable(cyc_q))
		else $error("T-state count changed outside the check step");

endmodule
`default_nettype wire
